[hdl/led_pattern_frame_parser_top_macros.svh]
// Assertion helpers for the frame parser top.
`ifndef LED_PATTERN_FRAME_PARSER_TOP_MACROS_SVH
`define LED_PATTERN_FRAME_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define LPFP_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ((pre) |-> (post))) \
        else $error("lpfp: same-cycle check failed");
// Next-cycle implication, disabled while in reset
`define LPFP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ((pre) |=> (post))) \
        else $error("lpfp: next-cycle check failed");
`else
`define LPFP_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define LPFP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

[hdl/lpfp_pkg.sv]
package lpfp_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIBER_COUNT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_COUNT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LEDS_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LEDS_HIGH = 8'd3;

    // Record kinds
    localparam logic [2:0] KIND_VERSION = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_FIBER   = 3'd2;
    localparam logic [2:0] KIND_LED     = 3'd3;
    localparam logic [2:0] KIND_VERDICT = 3'd4;

    localparam int OUT_TDATA_W = 128;

    // Register view handed to the parser, strip count already clamped
    typedef struct packed {
        logic [7:0]      fiber_count;
        logic [3:0]      strips_used;
        logic [7:0][7:0] strip_leds;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] frame_number;
        logic [31:0] word_value;
        logic        fade_on;
        logic [7:0]  group_index;
        logic [7:0]  led_index;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  blue;
        logic [31:0] computed_sum;
        logic        sum_ok;
    } record_t;

endpackage

[hdl/lpfp_cfg.sv]
module lpfp_cfg #(
    parameter int MAX_STRIPS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output lpfp_pkg::cfg_t                 cfg
);
    import lpfp_pkg::*;

    localparam logic [3:0] MAX_USED = 4'(MAX_STRIPS);

    logic [7:0]  fiber_count_reg;
    logic [3:0]  strip_count_reg;
    logic [31:0] leds_low_reg;
    logic [31:0] leds_high_reg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiber_count_reg <= 8'd0;
            strip_count_reg <= 4'd0;
            leds_low_reg    <= 32'd0;
            leds_high_reg   <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIBER_COUNT:     fiber_count_reg <= cfg_data[7:0];
                CFG_STRIP_COUNT:     strip_count_reg <= cfg_data[3:0];
                CFG_STRIP_LEDS_LOW:  leds_low_reg    <= cfg_data;
                CFG_STRIP_LEDS_HIGH: leds_high_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Clamp strip count and present LED counts per strip
    assign cfg.fiber_count = fiber_count_reg;
    assign cfg.strips_used = (strip_count_reg > MAX_USED) ? MAX_USED : strip_count_reg;
    assign cfg.strip_leds  = {leds_high_reg, leds_low_reg};

endmodule

[hdl/lpfp_parser.sv]
module lpfp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              stream_start,
    input  lpfp_pkg::cfg_t    cfg,
    input  logic              out_ready,
    output logic              out_valid,
    output lpfp_pkg::record_t out_rec
);
    import lpfp_pkg::*;

    typedef enum logic [2:0] {
        PH_VER_MAJOR,
        PH_VER_MINOR,
        PH_TIME,
        PH_FADE,
        PH_FIBER,
        PH_LED,
        PH_SUM
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [1:0]  byte_cnt_reg,  byte_cnt_next;
    logic [7:0]  fiber_pos_reg, fiber_pos_next;
    logic [2:0]  strip_pos_reg, strip_pos_next;
    logic [7:0]  led_pos_reg,   led_pos_next;
    logic [15:0] color_reg,     color_next;
    logic [31:0] word_reg,      word_next;
    logic [31:0] sum_reg,       sum_next;
    logic [15:0] frame_reg,     frame_next;
    logic [7:0]  major_reg,     major_next;
    logic        out_valid_reg;
    record_t     out_rec_reg;

    phase_t      phase_cur;
    logic [15:0] frame_cur;
    logic [31:0] sum_add;
    logic [31:0] word_shift;
    logic [7:0]  fiber_inc;
    logic [7:0]  led_inc;
    logic [7:0]  strip_mask;
    logic [3:0]  hit_first;
    logic [3:0]  hit_after;
    logic [3:0]  hit_sel;
    logic        use_strips;
    logic        rec_valid;
    record_t     rec;

    // First nonempty strip at or after a start index: {found, index}
    function automatic logic [3:0] first_strip(input logic [7:0] mask, input logic [3:0] from);
        logic [3:0] res;
        res = 4'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask[i] && (4'(i) >= from))
            begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    // Strips that are in use and not empty
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            strip_mask[i] = (cfg.strip_leds[i] != 8'd0) && (4'(i) < cfg.strips_used);
        end
    end

    assign hit_first  = first_strip(strip_mask, 4'd0);
    assign hit_after  = first_strip(strip_mask, {1'b0, strip_pos_reg} + 4'd1);
    assign phase_cur  = stream_start ? PH_VER_MAJOR : phase_reg;
    assign frame_cur  = stream_start ? 16'd0 : frame_reg;
    assign sum_add    = sum_reg + {24'd0, data_byte};
    assign word_shift = {data_byte, word_reg[31:8]};
    assign fiber_inc  = fiber_pos_reg + 8'd1;
    assign led_inc    = led_pos_reg + 8'd1;

    // Advance the parse by one byte
    always_comb
    begin
        phase_next     = phase_cur;
        byte_cnt_next  = byte_cnt_reg;
        fiber_pos_next = fiber_pos_reg;
        strip_pos_next = strip_pos_reg;
        led_pos_next   = led_pos_reg;
        color_next     = color_reg;
        word_next      = word_reg;
        sum_next       = sum_reg;
        frame_next     = frame_cur;
        major_next     = major_reg;
        rec            = '0;
        rec.frame_number = frame_cur;
        rec_valid      = 1'b0;
        use_strips     = 1'b0;
        hit_sel        = hit_first;

        unique case (phase_cur)
            PH_VER_MAJOR:
            begin
                major_next = data_byte;
                phase_next = PH_VER_MINOR;
            end
            PH_VER_MINOR:
            begin
                rec.kind       = KIND_VERSION;
                rec.word_value = {16'd0, major_reg, data_byte};
                rec_valid      = 1'b1;
                phase_next     = PH_TIME;
                byte_cnt_next  = 2'd0;
                sum_next       = 32'd0;
            end
            PH_TIME:
            begin
                sum_next  = sum_add;
                word_next = word_shift;
                if (byte_cnt_reg == 2'd3)
                begin
                    byte_cnt_next = 2'd0;
                    phase_next    = PH_FADE;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 2'd1;
                end
            end
            PH_FADE:
            begin
                sum_next       = sum_add;
                rec.kind       = KIND_HEADER;
                rec.word_value = word_reg;
                rec.fade_on    = (data_byte != 8'd0);
                rec_valid      = 1'b1;
                byte_cnt_next  = 2'd0;
                color_next     = 16'd0;
                if (cfg.fiber_count != 8'd0)
                begin
                    phase_next     = PH_FIBER;
                    fiber_pos_next = 8'd0;
                end
                else
                begin
                    use_strips = 1'b1;
                end
            end
            PH_FIBER,
            PH_LED:
            begin
                sum_next = sum_add;
                if (byte_cnt_reg < 2'd2)
                begin
                    color_next    = {color_reg[7:0], data_byte};
                    byte_cnt_next = byte_cnt_reg + 2'd1;
                end
                else
                begin
                    byte_cnt_next = 2'd0;
                    rec.green     = color_reg[15:8];
                    rec.red       = color_reg[7:0];
                    rec.blue      = data_byte;
                    rec_valid     = 1'b1;
                    color_next    = 16'd0;
                    if (phase_cur == PH_FIBER)
                    begin
                        rec.kind        = KIND_FIBER;
                        rec.group_index = fiber_pos_reg;
                        if ((fiber_inc == 8'd0) || (fiber_inc >= cfg.fiber_count))
                        begin
                            fiber_pos_next = 8'd0;
                            use_strips     = 1'b1;
                        end
                        else
                        begin
                            fiber_pos_next = fiber_inc;
                        end
                    end
                    else
                    begin
                        rec.kind        = KIND_LED;
                        rec.group_index = {5'd0, strip_pos_reg};
                        rec.led_index   = led_pos_reg;
                        if ((led_inc == 8'd0) || (led_inc >= cfg.strip_leds[strip_pos_reg]))
                        begin
                            led_pos_next = 8'd0;
                            use_strips   = 1'b1;
                            hit_sel      = hit_after;
                        end
                        else
                        begin
                            led_pos_next = led_inc;
                        end
                    end
                end
            end
            default:
            begin
                // Checksum bytes; an unused code closes the frame at once
                word_next = word_shift;
                if ((phase_cur == PH_SUM) && (byte_cnt_reg < 2'd3))
                begin
                    byte_cnt_next = byte_cnt_reg + 2'd1;
                end
                else
                begin
                    rec.kind         = KIND_VERDICT;
                    rec.word_value   = word_shift;
                    rec.computed_sum = sum_reg;
                    rec.sum_ok       = (word_shift == sum_reg);
                    rec_valid        = 1'b1;
                    frame_next       = frame_cur + 16'd1;
                    sum_next         = 32'd0;
                    byte_cnt_next    = 2'd0;
                    phase_next       = PH_TIME;
                end
            end
        endcase

        // Enter the next nonempty strip, else go to the checksum
        if (use_strips)
        begin
            if (hit_sel[3])
            begin
                phase_next     = PH_LED;
                strip_pos_next = hit_sel[2:0];
                led_pos_next   = 8'd0;
            end
            else
            begin
                phase_next = PH_SUM;
            end
        end
    end

    // Hold parse state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_VER_MAJOR;
            byte_cnt_reg  <= 2'd0;
            fiber_pos_reg <= 8'd0;
            strip_pos_reg <= 3'd0;
            led_pos_reg   <= 8'd0;
            color_reg     <= 16'd0;
            word_reg      <= 32'd0;
            sum_reg       <= 32'd0;
            frame_reg     <= 16'd0;
            major_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            out_rec_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            byte_cnt_reg  <= byte_cnt_next;
            fiber_pos_reg <= fiber_pos_next;
            strip_pos_reg <= strip_pos_next;
            led_pos_reg   <= led_pos_next;
            color_reg     <= color_next;
            word_reg      <= word_next;
            sum_reg       <= sum_next;
            frame_reg     <= frame_next;
            major_reg     <= major_next;
            out_valid_reg <= rec_valid;
            out_rec_reg   <= rec;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

[hdl/led_pattern_frame_parser_top.sv]
// LED pattern frame parser.
// Input stream: one byte per word on s_axis; s_axis_tuser marks the first
// version byte of a stream and restarts parsing and frame numbering.
// Output stream: at most one record per input byte on m_axis, the record
// kind in m_axis_tuser (version, frame header, fiber color, LED color,
// checksum verdict), the record fields packed in m_axis_tdata.
// Configuration: write-only port, cfg_index selects fiber count, strip
// count, LED counts of strips 0-3 and of strips 4-7; other indexes are
// ignored. cfg_ready is always high. Write only while the stream is idle.
// A record is presented from the result register: its last byte is first
// held in the input register, and the parse step loads the result register
// from it once the result register is free or being drained.
// Throughput: one byte per cycle while m_axis_tready is high, set by the
// combinational parse step between the input and result registers.
// Reset clears the registers to zero and expects a version byte first.
// When a record waits and m_axis_tready is low the result register holds;
// one more byte waits in the input register, after which s_axis_tready drops.
module led_pattern_frame_parser_top #(
    parameter int MAX_STRIPS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] data_byte
    input  logic                                 s_axis_tuser,  // [0] stream_start
    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] frame_number, [47:16] word_value, [48] fade_on,
    // [56:49] group_index, [64:57] led_index, [72:65] green, [80:73] red,
    // [88:81] blue, [120:89] computed_sum, [121] sum_ok, [127:122] zero
    output logic [lpfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [2:0]                           m_axis_tuser,  // [2:0] kind
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);
    import lpfp_pkg::*;

    `include "led_pattern_frame_parser_top_macros.svh"

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       step;
    logic       in_accept;
    cfg_t       cfg;
    record_t    out_rec;

    assign cfg_ready = 1'b1;

    lpfp_cfg #(
        .MAX_STRIPS (MAX_STRIPS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance when the result register is free or being drained
    assign step          = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    // Hold the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= 8'd0;
            in_start_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (in_accept)
            begin
                in_byte_reg  <= s_axis_tdata;
                in_start_reg <= s_axis_tuser;
            end
        end
    end

    lpfp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (in_byte_reg),
        .stream_start (in_start_reg),
        .cfg          (cfg),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_rec      (out_rec)
    );

    // Pack the record
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tdata = {6'd0, out_rec.sum_ok, out_rec.computed_sum, out_rec.blue,
                           out_rec.red, out_rec.green, out_rec.led_index,
                           out_rec.group_index, out_rec.fade_on, out_rec.word_value,
                           out_rec.frame_number};

    `LPFP_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, !s_axis_tready,
        in_valid_reg && m_axis_tvalid && !m_axis_tready)
    `LPFP_ASSERT_NEXT(a_input_word_kept, clk, rst_n, in_valid_reg && !step, in_valid_reg)
    `LPFP_ASSERT_IMPLY(a_verdict_consistent, clk, rst_n,
        m_axis_tvalid && (out_rec.kind == KIND_VERDICT),
        out_rec.sum_ok == (out_rec.word_value == out_rec.computed_sum))
    `LPFP_ASSERT_IMPLY(a_color_only_in_color, clk, rst_n,
        m_axis_tvalid && (out_rec.kind != KIND_FIBER) && (out_rec.kind != KIND_LED),
        (out_rec.green == 8'd0) && (out_rec.red == 8'd0) && (out_rec.blue == 8'd0))

endmodule
